[rtl/core/pbo_pkg.sv]
// Shared types and constants of the PolyBLEP multi-waveform oscillator.
`timescale 1ns / 1ps

package pbo_pkg;

  // Fixed field widths of the stream and configuration ports.
  localparam int FREQ_BITS      = 24;
  localparam int PERIOD_BITS    = 32;
  localparam int SAMPLE_BITS    = 20;
  localparam int OUT_TDATA_BITS = 24;

  // Q16 arithmetic constants.
  localparam int ONE_Q16    = 65536;
  localparam int SAMPLE_MAX = 524287;
  localparam int SAMPLE_MIN = -524288;

  // pi/2 in Q30, the argument scale of the sine series.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // The PolyBLEP quotient always stays below one in Q16.
  localparam int QUOT_BITS = 16;
  localparam int DIV_CNT_BITS = $clog2(QUOT_BITS + 1);

  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 32'd89478;

  // Configuration register indexes.
  localparam logic REG_WAVEFORM      = 1'b0;
  localparam logic REG_SAMPLE_PERIOD = 1'b1;

  typedef enum logic [1:0] {
    WAVE_SQUARE   = 2'd0,
    WAVE_SINE     = 2'd1,
    WAVE_SAW      = 2'd2,
    WAVE_TRIANGLE = 2'd3
  } waveform_t;

  typedef enum logic [1:0] {
    BLEP_NONE,
    BLEP_LOW,
    BLEP_HIGH
  } blep_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_INC,
    S_PHASE,
    S_SIN_MUL,
    S_SIN_RD,
    S_BLEP_SET,
    S_DIV,
    S_SQ,
    S_BLEP_FIN,
    S_RESULT
  } pbo_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pbo_div_stat_t;

endpackage

[rtl/core/pbo_div.sv]
// Restoring shift-subtract divider giving a 16-bit fraction for num < den.
`timescale 1ns / 1ps

module pbo_div
  import pbo_pkg::*;
#(
  parameter int W = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [W-1:0]         num,
  input  logic [W-1:0]         den,
  output pbo_div_stat_t        stat,
  output logic [QUOT_BITS-1:0] quot
);

  logic [DIV_CNT_BITS-1:0] cnt_r;
  logic                    done_r;
  logic [W-1:0]            rem_r;
  logic [W-1:0]            den_r;
  logic [QUOT_BITS-1:0]    quot_r;
  logic [W:0]              shifted;
  logic [W+1:0]            diff;
  logic                    fits;

  // The remainder stays below the divisor, so one extra bit holds the shift.
  assign shifted = {rem_r, 1'b0};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};
  assign fits    = !diff[W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= DIV_CNT_BITS'(QUOT_BITS);
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - DIV_CNT_BITS'(1);
        done_r <= (cnt_r == DIV_CNT_BITS'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
    end else if (cnt_r != '0) begin
      rem_r  <= fits ? diff[W-1:0] : shifted[W-1:0];
      quot_r <= {quot_r[QUOT_BITS-2:0], fits};
    end
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign quot      = quot_r;

endmodule

[rtl/core/polyblep_multiwave_oscillator_unit.sv]
// Top level of the PolyBLEP multi-waveform oscillator with its sequencer.
//
//   channel  direction  handshake                  payload
//   in_      slave      in_tvalid / in_tready      tdata[23:0] frequency
//   out_     master     out_tvalid / out_tready    tdata[19:0] sample
//   cfg_     slave      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A new frequency is taken only in the idle state, once the previous sample has
// gone to the output register. Square and saw wait on the serial divider for
// each blep that needs a correction; a blep that needs none skips the divider.
// Reset (rst_n low, synchronous) clears the phase and returns the waveform and
// period to their defaults.
// A finished sample waits in the output register; a stalled output holds the
// sequencer in its result state until that register is free.
`timescale 1ns / 1ps

module polyblep_multiwave_oscillator_unit
  import pbo_pkg::*;
#(
  parameter int PHASE_BITS         = 24,
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [FREQ_BITS-1:0]      in_tdata,   // [23:0] frequency
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0] out_tdata,  // [19:0] sample, [23:20] zero
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [PERIOD_BITS-1:0]    cfg_data
);

  localparam int QUARTER  = SINE_TABLE_ENTRIES / 4;
  localparam int FULL_TAB = 4 * QUARTER;
  localparam int IDX_W    = $clog2(FULL_TAB);
  localparam int ADDR_W   = $clog2(QUARTER + 1);
  localparam int SH_R     = (PHASE_BITS >= 16) ? PHASE_BITS - 16 : 0;
  localparam int SH_L     = (PHASE_BITS >= 16) ? 0 : 16 - PHASE_BITS;
  localparam int INC_LSB  = 40 - PHASE_BITS;
  localparam int MUL_A_W  = 32;
  localparam int MUL_P_W  = MUL_A_W + FREQ_BITS;

  // Taylor series of sin(x) for x in Q30, rounded to Q16.
  function automatic logic [16:0] sine_series(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 8192) / 16384;
    if (sum > ONE_Q16) sum = ONE_Q16;
    return 17'(sum);
  endfunction

  logic [16:0] sine_rom [QUARTER+1];

  for (genvar k = 0; k <= QUARTER; k++) begin : g_sine
    localparam longint unsigned X = (HALF_PI_Q30 * 64'(k)) / QUARTER;
    assign sine_rom[k] = sine_series(X);
  end

  pbo_state_t                state_r, state_nxt;
  waveform_t                 waveform_r;
  logic [PERIOD_BITS-1:0]    period_r;
  logic [PHASE_BITS-1:0]     phase_r;
  logic [PHASE_BITS-1:0]     inc_r;
  logic [FREQ_BITS-1:0]      freq_r;
  logic [MUL_P_W-1:0]        mul_r;
  logic                      pass_r;
  blep_kind_t                kind_r;
  logic signed [17:0]        blep_a_r;
  logic signed [17:0]        blep_b_r;
  logic [16:0]               rom_q_r;
  logic                      neg_r;
  logic                      out_tvalid_r;
  logic [SAMPLE_BITS-1:0]    out_sample_r;

  logic [MUL_A_W-1:0]        mul_a;
  logic [FREQ_BITS-1:0]      mul_b;
  logic                      div_start;
  logic                      out_load;
  pbo_div_stat_t             div_stat;
  logic [QUOT_BITS-1:0]      quot;

  logic                      in_accept;
  logic [PHASE_BITS-1:0]     inc_new;
  logic [PHASE_BITS-1:0]     ph_shift;
  logic [PHASE_BITS-1:0]     blep_t;
  logic [PHASE_BITS:0]       t_sum;
  blep_kind_t                kind;
  logic [PHASE_BITS-1:0]     div_num;
  logic [15:0]               sqh;
  logic signed [18:0]        blep_wide;
  logic signed [17:0]        blep_val;
  logic                      blep_last;
  logic [IDX_W-1:0]          idx;
  logic [1:0]                quad;
  logic [IDX_W-1:0]          quad_base;
  logic [IDX_W-1:0]          rem_idx;
  logic [ADDR_W-1:0]         rom_addr;
  logic [15:0]               phq;
  logic [15:0]               incq;
  logic [17:0]               tri4;
  logic signed [20:0]        y;
  logic signed [20:0]        one21;
  logic [SAMPLE_BITS-1:0]    y_sat;

  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Increment: saturate when the product reaches one full cycle.
  assign inc_new = (|mul_r[MUL_P_W-1:40]) ? '1 : mul_r[INC_LSB +: PHASE_BITS];

  // Second blep point for square: the phase moved by half a cycle.
  assign ph_shift = {~phase_r[PHASE_BITS-1], phase_r[PHASE_BITS-2:0]};
  assign blep_t   = pass_r ? ph_shift : phase_r;
  assign t_sum    = {1'b0, blep_t} + {1'b0, inc_r};

  always_comb begin
    if (inc_r == '0) kind = BLEP_NONE;
    else if (blep_t < inc_r) kind = BLEP_LOW;
    else if (t_sum[PHASE_BITS] && (t_sum[PHASE_BITS-1:0] != '0)) kind = BLEP_HIGH;
    else kind = BLEP_NONE;
  end

  // In the high branch the numerator is one minus t, taken modulo one cycle.
  assign div_num = (kind == BLEP_LOW) ? blep_t : ('0 - blep_t);

  pbo_div #(
    .W (PHASE_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (inc_r),
    .stat  (div_stat),
    .quot  (quot)
  );

  assign sqh = mul_r[31:16];

  always_comb begin
    if (kind_r == BLEP_LOW) begin
      blep_wide = signed'(19'({quot, 1'b0})) - signed'(19'(sqh)) - 19'(ONE_Q16);
    end else begin
      blep_wide = signed'(19'(sqh)) - signed'(19'({quot, 1'b0})) + 19'(ONE_Q16);
    end
    blep_val = 18'(blep_wide);
  end

  assign blep_last = !((waveform_r == WAVE_SQUARE) && !pass_r);

  // Sine address: quadrant by compare, mirrored index on odd quadrants.
  assign idx = mul_r[PHASE_BITS +: IDX_W];

  always_comb begin
    if (idx >= IDX_W'(3 * QUARTER)) begin
      quad      = 2'd3;
      quad_base = IDX_W'(3 * QUARTER);
    end else if (idx >= IDX_W'(2 * QUARTER)) begin
      quad      = 2'd2;
      quad_base = IDX_W'(2 * QUARTER);
    end else if (idx >= IDX_W'(QUARTER)) begin
      quad      = 2'd1;
      quad_base = IDX_W'(QUARTER);
    end else begin
      quad      = 2'd0;
      quad_base = '0;
    end
    rem_idx  = idx - quad_base;
    rom_addr = quad[0] ? (ADDR_W'(QUARTER) - ADDR_W'(rem_idx)) : ADDR_W'(rem_idx);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_accept) state_nxt = S_MUL_INC;
      S_MUL_INC:  state_nxt = S_PHASE;
      S_PHASE: begin
        unique case (waveform_r)
          WAVE_SINE:     state_nxt = S_SIN_MUL;
          WAVE_TRIANGLE: state_nxt = S_RESULT;
          default:       state_nxt = S_BLEP_SET;
        endcase
      end
      S_SIN_MUL:  state_nxt = S_SIN_RD;
      S_SIN_RD:   state_nxt = S_RESULT;
      S_BLEP_SET: begin
        if (kind != BLEP_NONE) state_nxt = S_DIV;
        else if (blep_last) state_nxt = S_RESULT;
        else state_nxt = S_BLEP_SET;
      end
      S_DIV:      if (div_stat.done) state_nxt = S_SQ;
      S_SQ:       state_nxt = S_BLEP_FIN;
      S_BLEP_FIN: state_nxt = blep_last ? S_RESULT : S_BLEP_SET;
      S_RESULT:   if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, output load, divider start and multiplier operands.
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    mul_a     = 32'(quot);
    mul_b     = 24'(quot);
    unique case (state_r)
      S_IDLE:     in_tready = 1'b1;
      S_MUL_INC: begin
        mul_a = period_r;
        mul_b = freq_r;
      end
      S_SIN_MUL: begin
        mul_a = 32'(phase_r);
        mul_b = 24'(FULL_TAB);
      end
      S_BLEP_SET: div_start = (kind != BLEP_NONE);
      S_RESULT:   out_load  = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      waveform_r   <= WAVE_SQUARE;
      period_r     <= PERIOD_RESET;
      phase_r      <= '0;
      pass_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_WAVEFORM:      waveform_r <= waveform_t'(cfg_data[1:0]);
          REG_SAMPLE_PERIOD: period_r   <= cfg_data;
        endcase
      end
      if (state_r == S_PHASE) phase_r <= phase_r + inc_new;
      if (in_accept) pass_r <= 1'b0;
      else if ((state_r == S_BLEP_SET && kind == BLEP_NONE) || state_r == S_BLEP_FIN) begin
        pass_r <= 1'b1;
      end
      if (out_load) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * MUL_A_W'(mul_b);
    // The table word is held so that a stalled result state still sees it.
    if (state_r == S_SIN_RD) begin
      rom_q_r <= sine_rom[rom_addr];
      neg_r   <= quad[1];
    end
    if (in_accept) freq_r <= in_tdata;
    if (state_r == S_PHASE) inc_r <= inc_new;
    if (state_r == S_BLEP_SET) begin
      kind_r <= kind;
      if (kind == BLEP_NONE) begin
        if (pass_r) blep_b_r <= '0;
        else blep_a_r <= '0;
      end
    end
    if (state_r == S_BLEP_FIN) begin
      if (pass_r) blep_b_r <= blep_val;
      else blep_a_r <= blep_val;
    end
    if (out_load) out_sample_r <= y_sat;
  end

  // Sample assembly in Q16 with a few guard bits.
  assign phq   = 16'((32'(phase_r) >> SH_R) << SH_L);
  assign incq  = 16'((32'(inc_r) >> SH_R) << SH_L);
  assign tri4  = {phq, 2'b00};
  assign one21 = 21'(ONE_Q16);

  always_comb begin
    case (waveform_r)
      WAVE_SQUARE: begin
        y = (phase_r[PHASE_BITS-1] ? -one21 : one21) + 21'(blep_a_r) - 21'(blep_b_r);
      end
      WAVE_SINE: begin
        y = neg_r ? -signed'(21'(rom_q_r)) : signed'(21'(rom_q_r));
      end
      WAVE_SAW: begin
        y = signed'(21'({phq, 1'b0})) - one21 - 21'(blep_a_r);
      end
      default: begin
        // Fold the upper part of the ramp back to make the triangle.
        if (tri4 >= 18'(3 * ONE_Q16)) y = signed'(21'(tri4)) - 21'(4 * ONE_Q16);
        else if (tri4 > 18'(ONE_Q16)) y = 21'(2 * ONE_Q16) - signed'(21'(tri4));
        else y = signed'(21'(tri4));
        y = y + signed'(21'({incq, 2'b00}));
      end
    endcase
    if (y > 21'(SAMPLE_MAX)) y_sat = SAMPLE_BITS'(SAMPLE_MAX);
    else if (y < 21'(SAMPLE_MIN)) y_sat = SAMPLE_BITS'(SAMPLE_MIN);
    else y_sat = y[SAMPLE_BITS-1:0];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(OUT_TDATA_BITS - SAMPLE_BITS)'(0), out_sample_r};

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == S_MUL_INC)
    else $error("accepted item did not start the increment multiply");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide wait state");

  a_div_wait_active: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> (div_stat.busy || div_stat.done))
    else $error("waiting on an idle divider");

  a_blep_sign: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BLEP_FIN |->
      ((kind_r == BLEP_LOW && blep_val <= 18'sd0) ||
       (kind_r == BLEP_HIGH && !blep_val[17])))
    else $error("blep residual has the wrong sign for its branch");

  a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT && (!out_tvalid_r || out_tready)) |=> out_tvalid_r)
    else $error("finished sample was not loaded into the output register");

endmodule

[tb/sv/polyblep_multiwave_oscillator_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the PolyBLEP oscillator: a directed table, then random segments.
module polyblep_multiwave_oscillator_unit_tb;
  import pbo_pkg::*;

  localparam int PW             = 24;
  localparam int SINE_ENTRIES   = 1024;
  localparam int QUARTER        = SINE_ENTRIES / 4;
  localparam int N_DIRECTED     = 25;
  localparam int RANDOM_ITEMS   = 1430;
  localparam int CALM_ITEMS     = 150;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AFTER     = 100;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 100;

  typedef longint unsigned u64_t;

  // One row of the directed table: a register write or a frequency transfer.
  typedef struct {
    bit          is_cfg;
    logic        reg_idx;
    logic [31:0] value;
    bit          has_exp;
    int          exp_sample;
  } step_t;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [FREQ_BITS-1:0]      in_tdata   = '0;   // [23:0] frequency
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] out_tdata;         // [19:0] sample, [23:20] zero
  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  logic                      cfg_index  = REG_WAVEFORM;
  logic [PERIOD_BITS-1:0]    cfg_data   = '0;

  // Oscillator state mirrored by the predictor.
  waveform_t              osc_wave;
  logic [PERIOD_BITS-1:0] osc_period;
  logic [PW-1:0]          osc_phase;
  int                     quarter_sine [0:QUARTER];

  logic [SAMPLE_BITS-1:0] pending_samples [$];
  int mismatches      = 0;
  int results_checked = 0;
  int idle_cycles     = 0;
  bit tx_idle         = 1'b0;
  bit rx_idle         = 1'b0;
  bit hold_done       = 1'b0;

  polyblep_multiwave_oscillator_unit #(
    .PHASE_BITS        (PW),
    .SINE_TABLE_ENTRIES(SINE_ENTRIES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Two-sided PolyBLEP residual in Q16; t and dt are in phase units.
  function automatic longint blep_residual(input logic [PW-1:0] t, input logic [PW-1:0] dt);
    longint tt, dd, one_cycle, q;
    tt = longint'(t);
    dd = longint'(dt);
    one_cycle = longint'(1) << PW;
    if (dd == 0) return 0;
    if (tt < dd) begin
      q = (tt << 16) / dd;
      return 2 * q - ((q * q) >>> 16) - ONE_Q16;
    end
    if (tt + dd > one_cycle) begin
      q = ((one_cycle - tt) << 16) / dd;
      return ((q * q) >>> 16) - 2 * q + ONE_Q16;
    end
    return 0;
  endfunction

  // Advances the phase by one tick and returns the sample the block must emit.
  function automatic logic [SAMPLE_BITS-1:0] predict_sample(input logic [FREQ_BITS-1:0] freq);
    u64_t          inc_wide;
    logic [PW-1:0] inc, half, opposite;
    longint        y, idx, quad, r;
    inc_wide = (u64_t'(freq) * u64_t'(osc_period)) >> (40 - PW);
    inc = (inc_wide > ((u64_t'(1) << PW) - 1)) ? '1 : inc_wide[PW-1:0];
    half = {1'b1, {(PW-1){1'b0}}};
    osc_phase = osc_phase + inc;
    opposite = osc_phase + half;
    y = 0;
    case (osc_wave)
      WAVE_SQUARE: begin
        y = (osc_phase < half) ? ONE_Q16 : -ONE_Q16;
        y += blep_residual(osc_phase, inc) - blep_residual(opposite, inc);
      end
      WAVE_SINE: begin
        idx = (longint'(osc_phase) * (4 * QUARTER)) >>> PW;
        quad = idx / QUARTER;
        r = idx % QUARTER;
        case (quad)
          0:       y = quarter_sine[r];
          1:       y = quarter_sine[QUARTER - r];
          2:       y = -quarter_sine[r];
          default: y = -quarter_sine[QUARTER - r];
        endcase
      end
      WAVE_SAW: begin
        y = 2 * longint'(osc_phase >> (PW - 16)) - ONE_Q16 - blep_residual(osc_phase, inc);
      end
      WAVE_TRIANGLE: begin
        y = 4 * longint'(osc_phase >> (PW - 16));
        if (y >= 3 * ONE_Q16) y -= 4 * ONE_Q16;
        else if (y > ONE_Q16) y = 2 * ONE_Q16 - y;
        y += 4 * longint'(inc >> (PW - 16));
      end
    endcase
    if (y > SAMPLE_MAX) y = SAMPLE_MAX;
    if (y < SAMPLE_MIN) y = SAMPLE_MIN;
    return y[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic [FREQ_BITS-1:0] pick_frequency();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 24'd1 << $urandom_range(0, FREQ_BITS - 1);
      3, 4:    return 24'($urandom_range(0, 16'hFFFF));
      default: return 24'($urandom());
    endcase
  endfunction

  // Offers one frequency; the expectation is queued at the edge of its transfer.
  task automatic send_frequency(input logic [FREQ_BITS-1:0] freq, input bit has_exp,
                                input int exp_sample);
    int                     gap;
    logic [SAMPLE_BITS-1:0] predicted;
    gap = (tx_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= freq;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = predict_sample(freq);
    pending_samples.push_back(has_exp ? exp_sample[SAMPLE_BITS-1:0] : predicted);
  endtask

  // Register writes only go out once every pending sample has come back.
  task automatic write_register(input logic idx, input logic [PERIOD_BITS-1:0] value);
    in_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_WAVEFORM) osc_wave = waveform_t'(value[1:0]);
    else osc_period = value;
  endtask

  always @(posedge clk) begin : result_check
    logic [SAMPLE_BITS-1:0] expected;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("sample transfer with no expectation waiting");
      end else begin
        expected = pending_samples.pop_front();
        if (out_tdata[SAMPLE_BITS-1:0] !== expected)
          report_mismatch($sformatf("sample %0d, expected %0d",
                                    $signed(out_tdata[SAMPLE_BITS-1:0]), $signed(expected)));
        if (out_tdata[OUT_TDATA_BITS-1:SAMPLE_BITS] !== '0)
          report_mismatch("nonzero padding above the sample");
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: short random stalls, plus one long hold that backs the block up.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && results_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        stall_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    step_t                  directed_steps [N_DIRECTED];
    u64_t                   x, x2, term;
    longint                 sum, v;
    int                     sent, seg_len;
    bit                     calm;
    logic [FREQ_BITS-1:0]   base_freq;
    logic [PERIOD_BITS-1:0] period_pick;

    // Quarter-wave sine table from the same integer series the block uses.
    for (int k = 0; k <= QUARTER; k++) begin
      x = (HALF_PI_Q30 * u64_t'(k)) / u64_t'(QUARTER);
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = (term * x2) >> 30;
        term = term / u64_t'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (sum + 8192) / 16384;
      if (v > ONE_Q16) v = ONE_Q16;
      quarter_sine[k] = int'(v);
    end
    osc_wave   = WAVE_SQUARE;
    osc_period = PERIOD_RESET;
    osc_phase  = '0;

    directed_steps = '{
      // Right after reset the phase is zero and the square wave sits high.
      '{1'b0, REG_WAVEFORM,      32'h00_0000,         1'b1, ONE_Q16},
      // Full-scale frequency drives the increment into saturation.
      '{1'b0, REG_WAVEFORM,      32'hFF_FFFF,         1'b0, 0},
      // A zero period gives a zero increment, so no blep correction.
      '{1'b1, REG_SAMPLE_PERIOD, 32'h0000_0000,       1'b0, 0},
      '{1'b0, REG_WAVEFORM,      32'hAB_CDEF,         1'b1, -ONE_Q16},
      '{1'b1, REG_WAVEFORM,      32'(WAVE_SAW),       1'b0, 0},
      '{1'b0, REG_WAVEFORM,      32'h12_3456,         1'b1, 65534},
      '{1'b1, REG_WAVEFORM,      32'(WAVE_TRIANGLE),  1'b0, 0},
      '{1'b0, REG_WAVEFORM,      32'h00_0000,         1'b1, -4},
      '{1'b1, REG_WAVEFORM,      32'(WAVE_SINE),      1'b0, 0},
      '{1'b0, REG_WAVEFORM,      32'h80_0000,         1'b0, 0},
      '{1'b1, REG_SAMPLE_PERIOD, 32'hFFFF_FFFF,       1'b0, 0},
      '{1'b0, REG_WAVEFORM,      32'h00_0001,         1'b0, 0},
      '{1'b0, REG_WAVEFORM,      32'hFF_FFFF,         1'b0, 0},
      '{1'b1, REG_WAVEFORM,      32'(WAVE_SQUARE),    1'b0, 0},
      '{1'b0, REG_WAVEFORM,      32'h55_5555,         1'b0, 0},
      '{1'b0, REG_WAVEFORM,      32'hAA_AAAA,         1'b0, 0},
      '{1'b1, REG_WAVEFORM,      32'(WAVE_SAW),       1'b0, 0},
      '{1'b0, REG_WAVEFORM,      32'h00_0001,         1'b0, 0},
      '{1'b0, REG_WAVEFORM,      32'hFF_FFFF,         1'b0, 0},
      '{1'b1, REG_SAMPLE_PERIOD, 32'(PERIOD_RESET),   1'b0, 0},
      '{1'b1, REG_WAVEFORM,      32'(WAVE_TRIANGLE),  1'b0, 0},
      '{1'b0, REG_WAVEFORM,      32'h01_B800,         1'b0, 0},
      '{1'b1, REG_WAVEFORM,      32'(WAVE_SINE),      1'b0, 0},
      '{1'b0, REG_WAVEFORM,      32'h01_B800,         1'b0, 0},
      '{1'b0, REG_WAVEFORM,      32'h00_03E8,         1'b0, 0}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_steps[i].is_cfg)
        write_register(directed_steps[i].reg_idx, directed_steps[i].value);
      else
        send_frequency(directed_steps[i].value[FREQ_BITS-1:0], directed_steps[i].has_exp,
                       directed_steps[i].exp_sample);
    end

    // Random segments: each holds one setting and mostly one steady frequency,
    // so the phase actually wraps and the blep branches get exercised.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = (RANDOM_ITEMS - sent) <= CALM_ITEMS;
      write_register(REG_WAVEFORM, $urandom_range(WAVE_SQUARE, WAVE_TRIANGLE));
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0:       period_pick = '0;
          1:       period_pick = '1;
          2:       period_pick = PERIOD_RESET;
          3:       period_pick = $urandom();
          default: period_pick = $urandom_range(1, 32'h0010_0000);
        endcase
        write_register(REG_SAMPLE_PERIOD, period_pick);
      end
      tx_idle = !calm && ($urandom_range(0, 2) != 0);
      rx_idle = !calm && ($urandom_range(0, 2) != 0);
      if (calm) seg_len = RANDOM_ITEMS - sent;
      else begin
        seg_len = $urandom_range(20, 120);
        if (seg_len > RANDOM_ITEMS - CALM_ITEMS - sent) seg_len = RANDOM_ITEMS - CALM_ITEMS - sent;
      end
      base_freq = pick_frequency();
      repeat (seg_len) begin
        send_frequency(($urandom_range(0, 3) != 0) ? base_freq : pick_frequency(), 1'b0, 0);
        sent++;
      end
    end
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;

    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/pbo_pkg.sv
rtl/core/pbo_div.sv
rtl/core/polyblep_multiwave_oscillator_unit.sv
tb/sv/polyblep_multiwave_oscillator_unit_tb.sv
